/* hw/rtl/mcc_pkg.sv */
package mcc_pkg;

    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_UC = 8'h43;
    localparam logic [7:0] CHAR_LC = 8'h63;
    localparam logic [7:0] CHAR_UG = 8'h47;
    localparam logic [7:0] CHAR_LG = 8'h67;

    localparam logic [1:0] CTX_CG  = 2'd0;
    localparam logic [1:0] CTX_CHG = 2'd1;
    localparam logic [1:0] CTX_CHH = 2'd2;

    localparam logic STRAND_C = 1'b0;
    localparam logic STRAND_G = 1'b1;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_req;
    } in_item_t;

    typedef struct packed {
        logic [15:0] record_index;
        logic [31:0] base_position;
        logic        strand;
        logic [1:0]  site_context;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                      count;
        out_item_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

endpackage

/* hw/rtl/mcc_front.sv */
module mcc_front #(
    parameter int POSITION_BITS = 32,
    parameter int RECORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  mcc_pkg::in_item_t  text,
    input  logic               q_full,
    output logic               q_push,
    output mcc_pkg::bundle_t   q_data
);

    logic                     in_header_reg, in_header_next;
    logic                     at_line_start_reg, at_line_start_next;
    logic                     prev_one_is_c_reg, prev_one_is_c_next;
    logic                     prev_two_is_c_reg, prev_two_is_c_next;
    logic                     pending_c_near_reg, pending_c_near_next;
    logic                     pending_c_far_reg, pending_c_far_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [RECORD_BITS-1:0]   record_reg, record_next;
    logic [POSITION_BITS-1:0] near_pos_reg, near_pos_next;
    logic [POSITION_BITS-1:0] far_pos_reg, far_pos_next;
    mcc_pkg::bundle_t         bundle;
    logic                     accept;
    logic                     is_c;
    logic                     is_g;
    logic [15:0]              rec16;

    function automatic logic [31:0] low32(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    function automatic logic [15:0] low16(input logic [RECORD_BITS-1:0] v);
        logic [RECORD_BITS+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    function automatic mcc_pkg::bundle_t add(
        input mcc_pkg::bundle_t         b,
        input logic [15:0]              rec,
        input logic [POSITION_BITS-1:0] pos,
        input logic                     strand,
        input logic [1:0]               ctx
    );
        mcc_pkg::bundle_t r;
        r = b;
        if (r.count < 2'(mcc_pkg::MAX_RESULTS))
        begin
            r.res[r.count].record_index  = rec;
            r.res[r.count].base_position = low32(pos);
            r.res[r.count].strand        = strand;
            r.res[r.count].site_context  = ctx;
            r.res[r.count].last          = 1'b0;
            r.count                      = r.count + 2'd1;
        end
        return r;
    endfunction

    assign text_ready = !q_full;
    assign accept     = text_valid && text_ready;
    assign rec16      = low16(record_reg);
    assign is_c       = (text.text_byte == mcc_pkg::CHAR_UC) ||
                        (text.text_byte == mcc_pkg::CHAR_LC);
    assign is_g       = (text.text_byte == mcc_pkg::CHAR_UG) ||
                        (text.text_byte == mcc_pkg::CHAR_LG);

    always_comb
    begin
        in_header_next      = in_header_reg;
        at_line_start_next  = at_line_start_reg;
        prev_one_is_c_next  = prev_one_is_c_reg;
        prev_two_is_c_next  = prev_two_is_c_reg;
        pending_c_near_next = pending_c_near_reg;
        pending_c_far_next  = pending_c_far_reg;
        position_next       = position_reg;
        record_next         = record_reg;
        near_pos_next       = near_pos_reg;
        far_pos_next        = far_pos_reg;
        bundle              = '0;

        if (text.text_byte == mcc_pkg::CHAR_NL)
        begin
            if (pending_c_far_next)
                bundle = add(bundle, rec16, far_pos_next, mcc_pkg::STRAND_C, mcc_pkg::CTX_CHH);
            if (pending_c_near_next)
                bundle = add(bundle, rec16, near_pos_next, mcc_pkg::STRAND_C, mcc_pkg::CTX_CHH);
            pending_c_far_next  = 1'b0;
            pending_c_near_next = 1'b0;
            prev_one_is_c_next  = 1'b0;
            prev_two_is_c_next  = 1'b0;
            at_line_start_next  = 1'b1;
            in_header_next      = 1'b0;
        end
        else if (in_header_reg)
        begin
            in_header_next = 1'b1;
        end
        else if (at_line_start_reg && (text.text_byte == mcc_pkg::CHAR_GT))
        begin
            in_header_next     = 1'b1;
            at_line_start_next = 1'b0;
            if (!(&record_reg))
                record_next = record_reg + RECORD_BITS'(1);
            position_next = '0;
        end
        else
        begin
            at_line_start_next = 1'b0;
            if (!(&position_reg))
                position_next = position_reg + POSITION_BITS'(1);
            if (pending_c_far_reg)
            begin
                bundle = add(bundle, rec16, far_pos_reg, mcc_pkg::STRAND_C,
                             is_g ? mcc_pkg::CTX_CHG : mcc_pkg::CTX_CHH);
                pending_c_far_next = 1'b0;
            end
            if (pending_c_near_reg)
            begin
                if (is_g)
                    bundle = add(bundle, rec16, near_pos_reg, mcc_pkg::STRAND_C,
                                 mcc_pkg::CTX_CG);
                else
                begin
                    pending_c_far_next = 1'b1;
                    far_pos_next       = near_pos_reg;
                end
                pending_c_near_next = 1'b0;
            end
            if (is_g)
                bundle = add(bundle, rec16, position_next, mcc_pkg::STRAND_G,
                             prev_one_is_c_reg ? mcc_pkg::CTX_CG :
                             (prev_two_is_c_reg ? mcc_pkg::CTX_CHG : mcc_pkg::CTX_CHH));
            if (is_c)
            begin
                pending_c_near_next = 1'b1;
                near_pos_next       = position_next;
            end
            prev_two_is_c_next = prev_one_is_c_reg;
            prev_one_is_c_next = is_c;
        end

        if (text.final_req)
        begin
            if (pending_c_far_next)
                bundle = add(bundle, rec16, far_pos_next, mcc_pkg::STRAND_C, mcc_pkg::CTX_CHH);
            if (pending_c_near_next)
                bundle = add(bundle, rec16, near_pos_next, mcc_pkg::STRAND_C, mcc_pkg::CTX_CHH);
            pending_c_far_next  = 1'b0;
            pending_c_near_next = 1'b0;
            prev_one_is_c_next  = 1'b0;
            prev_two_is_c_next  = 1'b0;
            at_line_start_next  = 1'b1;
            in_header_next      = 1'b0;
        end

        if (bundle.count != 2'd0)
            bundle.res[bundle.count - 2'd1].last = 1'b1;
    end

    assign q_push = accept && (bundle.count != 2'd0);
    assign q_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg      <= 1'b0;
            at_line_start_reg  <= 1'b1;
            prev_one_is_c_reg  <= 1'b0;
            prev_two_is_c_reg  <= 1'b0;
            pending_c_near_reg <= 1'b0;
            pending_c_far_reg  <= 1'b0;
            position_reg       <= '0;
            record_reg         <= '0;
        end
        else if (accept)
        begin
            in_header_reg      <= in_header_next;
            at_line_start_reg  <= at_line_start_next;
            prev_one_is_c_reg  <= prev_one_is_c_next;
            prev_two_is_c_reg  <= prev_two_is_c_next;
            pending_c_near_reg <= pending_c_near_next;
            pending_c_far_reg  <= pending_c_far_next;
            position_reg       <= position_next;
            record_reg         <= record_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            near_pos_reg <= near_pos_next;
            far_pos_reg  <= far_pos_next;
        end
    end

endmodule

/* hw/rtl/mcc_queue.sv */
module mcc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mcc_pkg::bundle_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output mcc_pkg::bundle_t head
);

    mcc_pkg::bundle_t                   mem [mcc_pkg::QUEUE_DEPTH];
    logic [mcc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcc_pkg::QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full  = (count_reg == (mcc_pkg::QUEUE_PTR_BITS+1)'(mcc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + (mcc_pkg::QUEUE_PTR_BITS)'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + (mcc_pkg::QUEUE_PTR_BITS)'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (mcc_pkg::QUEUE_PTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (mcc_pkg::QUEUE_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* hw/rtl/mcc_back.sv */
module mcc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  mcc_pkg::bundle_t   q_head,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_ready,
    output mcc_pkg::out_item_t result
);

    logic [1:0]         idx_reg, idx_next;
    logic               valid_reg, valid_next;
    mcc_pkg::out_item_t data_reg, data_next;
    logic               load;
    logic               take;
    logic               at_end;

    assign load   = !valid_reg || result_ready;
    assign take   = load && !q_empty;
    assign at_end = (idx_reg == q_head.count - 2'd1);
    assign q_pop  = take && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take)
        begin
            valid_next = 1'b1;
            data_next  = q_head.res[idx_reg];
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

/* hw/rtl/methylation_context_classifier.sv */
// CG / CHG / CHH context classifier over a FASTA byte stream.
// Input channel text (text_valid / text_ready): one file byte per transfer,
// with final_req set on the last byte of the file.
// Output channel result (result_valid / result_ready): one classified C or G
// base per transfer; last marks the final result caused by an input byte.
// A byte is classified in the cycle it is taken; its results, if any (up to
// three), go as one entry into a four-entry queue, and the output stage
// drains that entry one result per cycle while result_ready allows. The
// first result of a byte passes through the queue and the output register.
// Throughput: one byte per cycle while the queue has room; the output side
// moves one result per cycle while not stalled, so a byte with three results
// takes three output transfers. A stalled receiver holds its result; the
// queue fills and text_ready drops only when four entries are waiting.
// Reset clears the line and header state, both counters, the queue and the
// output valid flag; the first byte may follow right after reset.
module methylation_context_classifier #(
    parameter int POSITION_BITS = 32,
    parameter int RECORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  mcc_pkg::in_item_t  text,
    output logic               result_valid,
    input  logic               result_ready,
    output mcc_pkg::out_item_t result
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    mcc_pkg::bundle_t q_in;
    mcc_pkg::bundle_t q_head;

    mcc_front #(
        .POSITION_BITS(POSITION_BITS),
        .RECORD_BITS(RECORD_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text(text),
        .q_full(q_full),
        .q_push(q_push),
        .q_data(q_in)
    );

    mcc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(q_in),
        .pop(q_pop),
        .full(q_full),
        .empty(q_empty),
        .head(q_head)
    );

    mcc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> result_valid && result.last)
        else $error("entry retired without last result");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_in.count != 2'd0)
        else $error("empty entry queued");

endmodule
